[rtl/block_pair_presence_histogram_unit_macros.svh]
// Assertion macros for the pair presence histogram checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BLOCK_PAIR_PRESENCE_HISTOGRAM_UNIT_MACROS_SVH
`define BLOCK_PAIR_PRESENCE_HISTOGRAM_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BPPH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpph check failed");

// antecedent implies consequent in the next cycle
`define BPPH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpph check failed");

`endif

[rtl/bpph_pkg.sv]
// Shared types and constants for the pair presence histogram.
// No dependencies.
package bpph_pkg;

    localparam int OUT_W   = 20;
    localparam int GROUP_W = 4;
    localparam int CODE_W  = 2;

    localparam logic       FUNC_ACCUM  = 1'b0;
    localparam logic       FUNC_READ   = 1'b1;
    localparam logic [1:0] OBS_ABSENT  = 2'd0;
    localparam logic [1:0] OBS_PRESENT = 2'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } bpph_state_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic commit;
    } bpph_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } bpph_status_t;

endpackage

[rtl/bpph_ctrl.sv]
// Sequencer for the pair presence histogram: table clear, capture, update.
// Depends on bpph_pkg.
module bpph_ctrl
    import bpph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  bpph_status_t status,
    output bpph_cmd_t    cmd
);

    bpph_state_t state_reg;
    bpph_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        item_ready   = (state_reg == ST_IDLE);
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.capture  = (state_reg == ST_IDLE) && item_valid;
        cmd.commit   = (state_reg == ST_UPDATE) && status.out_free;
    end

endmodule

[rtl/bpph_datapath.sv]
// Count tables, saturating update and result register.
// Depends on bpph_pkg.
module bpph_datapath
    import bpph_pkg::*;
#(
    parameter int LOC_GROUPS = 16,
    parameter int SPP_GROUPS = 16,
    parameter int COUNT_BITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bpph_cmd_t          cmd,
    output bpph_status_t       status,
    input  logic               func,
    input  logic [GROUP_W-1:0] location_group,
    input  logic [GROUP_W-1:0] species_group,
    input  logic [CODE_W-1:0]  obs_code,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [OUT_W-1:0]   present_count,
    output logic [OUT_W-1:0]   absent_count
);

    localparam int DEPTH  = LOC_GROUPS * SPP_GROUPS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = 17;
    localparam int CMP_W  = 9;

    logic [COUNT_BITS-1:0] present_mem [DEPTH];
    logic [COUNT_BITS-1:0] absent_mem  [DEPTH];

    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  func_reg;
    logic [CODE_W-1:0]     code_reg;
    logic                  in_range_reg;
    logic [COUNT_BITS-1:0] present_rd_reg;
    logic [COUNT_BITS-1:0] absent_rd_reg;
    logic                  valid_reg;
    logic [OUT_W-1:0]      present_out_reg;
    logic [OUT_W-1:0]      absent_out_reg;

    logic [IDX_W-1:0]      idx_wide;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  in_range;
    logic                  inc_present;
    logic                  inc_absent;
    logic [COUNT_BITS-1:0] present_new;
    logic [COUNT_BITS-1:0] absent_new;
    logic                  wr_present;
    logic                  wr_absent;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] present_wr_data;
    logic [COUNT_BITS-1:0] absent_wr_data;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

    assign idx_wide = IDX_W'(location_group) * IDX_W'(SPP_GROUPS) + IDX_W'(species_group);
    assign rd_addr  = idx_wide[ADDR_W-1:0];
    assign in_range = (CMP_W'(location_group) < CMP_W'(LOC_GROUPS))
                   && (CMP_W'(species_group) < CMP_W'(SPP_GROUPS));

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    assign status.clear_last = cmd.clear_wr && (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.out_free   = !valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg       <= rd_addr;
            func_reg       <= func;
            code_reg       <= obs_code;
            in_range_reg   <= in_range;
            present_rd_reg <= present_mem[rd_addr];
            absent_rd_reg  <= absent_mem[rd_addr];
        end
    end

    assign inc_present = in_range_reg && (func_reg == FUNC_ACCUM) && (code_reg == OBS_PRESENT);
    assign inc_absent  = in_range_reg && (func_reg == FUNC_ACCUM) && (code_reg == OBS_ABSENT);
    assign present_new = inc_present ? sat_inc(present_rd_reg) : present_rd_reg;
    assign absent_new  = inc_absent  ? sat_inc(absent_rd_reg)  : absent_rd_reg;

    assign wr_present      = cmd.clear_wr || (cmd.commit && inc_present);
    assign wr_absent       = cmd.clear_wr || (cmd.commit && inc_absent);
    assign wr_addr         = cmd.clear_wr ? clr_cnt_reg : addr_reg;
    assign present_wr_data = cmd.clear_wr ? '0 : present_new;
    assign absent_wr_data  = cmd.clear_wr ? '0 : absent_new;

    always_ff @(posedge clk)
    begin
        if (wr_present)
        begin
            present_mem[wr_addr] <= present_wr_data;
        end
        if (wr_absent)
        begin
            absent_mem[wr_addr] <= absent_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            present_out_reg <= in_range_reg ? OUT_W'(present_new) : '0;
            absent_out_reg  <= in_range_reg ? OUT_W'(absent_new)  : '0;
        end
    end

    assign result_valid  = valid_reg;
    assign present_count = present_out_reg;
    assign absent_count  = absent_out_reg;

endmodule

[rtl/block_pair_presence_histogram_unit.sv]
// Pair presence histogram: present/absent count tables per group pair.
// Depends on bpph_pkg, bpph_ctrl, bpph_datapath.
//
// Input channel item_valid/item_ready carries one word per matrix cell:
// func, location_group, species_group, obs_code. Output channel
// result_valid/result_ready returns one word per input word with the
// present and absent counts of the pair after any update (zero for a pair
// outside the configured groups). Counts saturate at 2^COUNT_BITS-1.
// Result path: an accepted word is captured with its table entries, and the
// update step registers its result when the output register is free.
// Flow: no new word is accepted until the last one is written back, set
// by the read-modify-write of the count tables (read at accept, write on
// commit). Reset: a clear pass over all LOC_GROUPS*SPP_GROUPS entries
// zeroes both tables; item_ready stays low until it finishes.
// Stall: a held result keeps its output register; the next word is still
// accepted, and its update waits until the held result is taken.
module block_pair_presence_histogram_unit
    import bpph_pkg::*;
#(
    parameter int LOC_GROUPS = 16,
    parameter int SPP_GROUPS = 16,
    parameter int COUNT_BITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               func,
    input  logic [GROUP_W-1:0] location_group,
    input  logic [GROUP_W-1:0] species_group,
    input  logic [CODE_W-1:0]  obs_code,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [OUT_W-1:0]   present_count,
    output logic [OUT_W-1:0]   absent_count
);

    bpph_cmd_t    cmd;
    bpph_status_t status;

    bpph_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    bpph_datapath #(
        .LOC_GROUPS (LOC_GROUPS),
        .SPP_GROUPS (SPP_GROUPS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .func           (func),
        .location_group (location_group),
        .species_group  (species_group),
        .obs_code       (obs_code),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .present_count  (present_count),
        .absent_count   (absent_count)
    );

endmodule

[rtl/bpph_checker.sv]
// Port-level checks for block_pair_presence_histogram_unit, bound to it.
// Depends on block_pair_presence_histogram_unit_macros.svh and bpph_pkg.
`include "block_pair_presence_histogram_unit_macros.svh"

module bpph_checker
    import bpph_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input logic [OUT_W-1:0] present_count,
    input logic [OUT_W-1:0] absent_count
);

    logic [2*OUT_W-1:0] counts;

    assign counts = {present_count, absent_count};

    // one word in flight: no acceptance on the cycle after one
    `BPPH_ASSERT_NEXT(a_no_back_to_back, item_valid && item_ready, !item_ready)

    // a new result only comes out of the update step, when input is closed
    `BPPH_ASSERT_NOW(a_result_from_update, $rose(result_valid), $past(!item_ready))

    `BPPH_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(counts))

endmodule

bind block_pair_presence_histogram_unit bpph_checker u_bpph_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .present_count (present_count),
    .absent_count  (absent_count)
);
